FILE: design/bpa_pkg.sv
// Shared types and constants for the buffer pool allocator.
// Holds the request, result, command and configuration structs and the op and status codes.
// No dependencies.
package bpa_pkg;

	// Default capacity of the free-id queue.
	localparam int MaxBuffersDefault = 1024;

	// Width of a stored id: wide enough for any id below the largest buffer count.
	localparam int IdW = 11;

	// Configuration register indexes.
	localparam logic [1:0] CfgBaseAddress  = 2'd0;
	localparam logic [1:0] CfgBufferLength = 2'd1;
	localparam logic [1:0] CfgBufferCount  = 2'd2;
	localparam logic [1:0] CfgLocalKey     = 2'd3;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ACQ_ANY = 2'd1,
		OP_ACQ_ID  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_OPEN    = 2'd2,
		STATUS_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [9:0]  buffer_id;
		logic [31:0] request_length;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  granted_id;
		logic [63:0] address;
		logic [31:0] granted_length;
		logic [31:0] key;
	} result_t;

	// Decoded command handed from the front part to the back part.
	typedef struct packed {
		op_t         op;
		logic [9:0]  buffer_id;
		logic [31:0] request_length;
		logic        len_ok;
	} cmd_t;

	typedef struct packed {
		logic [63:0] base_address;
		logic [31:0] buffer_length;
		logic [10:0] buffer_count;
		logic [31:0] local_key;
	} cfg_t;

endpackage

FILE: design/bpa_fifo.sv
// Small synchronous FIFO used between the parts of the buffer pool allocator.
// Generic over the payload type; no package dependency.
module bpa_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	T                slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntFull);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/bpa_front.sv
// Front part of the buffer pool allocator: takes requests and queues decoded commands.
// Depends on bpa_pkg and bpa_fifo.
module bpa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bpa_pkg::request_t request,
	input  logic [31:0]       buffer_length,
	input  logic              cmd_pop,
	output bpa_pkg::cmd_t     cmd,
	output logic              cmd_empty
);

	bpa_pkg::cmd_t dec;

	// Decode the request; the length check is settled here so the back part only
	// has the id check and the multiply left.
	always_comb begin
		dec.op             = request.op;
		dec.buffer_id      = request.buffer_id;
		dec.request_length = request.request_length;
		dec.len_ok         = (request.request_length <= buffer_length);
	end

	// Short command queue that lets the front and back stall independently.
	bpa_fifo #(
		.T     (bpa_pkg::cmd_t),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (dec),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

endmodule

FILE: design/bpa_back.sv
// Back part of the buffer pool allocator: free-id queue memory, init fill and grant arithmetic.
// Depends on bpa_pkg.
module bpa_back #(
	parameter int MAX_BUFFERS = bpa_pkg::MaxBuffersDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bpa_pkg::cfg_t    cfg,
	input  logic             cmd_empty,
	input  bpa_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_valid,
	output bpa_pkg::result_t res
);

	localparam int PtrW  = $clog2(MAX_BUFFERS);
	localparam int CntW  = $clog2(MAX_BUFFERS + 1);
	localparam int IdW   = bpa_pkg::IdW;
	localparam int ProdW = IdW + 32;
	localparam logic [PtrW-1:0] PtrLast = PtrW'(MAX_BUFFERS - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(MAX_BUFFERS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_MUL,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t           state_q;
	bpa_pkg::cmd_t    cmd_q;
	logic             open_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [PtrW-1:0]  wr_ptr_q;
	logic [CntW-1:0]  count_q;
	logic [IdW-1:0]   fill_q;
	logic [IdW-1:0]   fill_n_q;
	logic [IdW-1:0]   rd_data_q;
	logic [ProdW-1:0] prod_q;
	logic             ok_q;
	logic [IdW-1:0]   id_q;
	bpa_pkg::result_t res_q;

	logic [IdW-1:0]   mem [MAX_BUFFERS];

	logic             q_full;
	logic             q_empty;
	logic             mem_we;
	logic             mem_re;
	logic [IdW-1:0]   mem_wdata;
	logic             fill_done;
	logic [IdW-1:0]   fill_limit;
	logic [IdW-1:0]   id_sel;

	// Pack one whole result so each update of the result register is a single assignment.
	function automatic bpa_pkg::result_t make_result(
		input bpa_pkg::status_t status,
		input logic [9:0]       granted_id,
		input logic [63:0]      address,
		input logic [31:0]      granted_length,
		input logic [31:0]      key
	);
		bpa_pkg::result_t r;
		r.status         = status;
		r.granted_id     = granted_id;
		r.address        = address;
		r.granted_length = granted_length;
		r.key            = key;
		return r;
	endfunction

	assign q_full    = (count_q == CntFull);
	assign q_empty   = (count_q == '0);
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign fill_done = (fill_q == fill_n_q) || q_full;
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	// Most ids an init queues: the buffer count, capped at the queue capacity.
	assign fill_limit = (32'(cfg.buffer_count) > 32'(MAX_BUFFERS)) ?
		IdW'(MAX_BUFFERS) : cfg.buffer_count;

	// Granted id comes from the queue head on acquire-any, else from the command.
	assign id_sel = (cmd_q.op == bpa_pkg::OP_ACQ_ANY) ? rd_data_q : IdW'(cmd_q.buffer_id);

	// Queue memory port control: one push or one pop per cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = fill_q;
		if (state_q == ST_IDLE && !cmd_empty) begin
			if (cmd.op == bpa_pkg::OP_RELEASE && !q_full) begin
				mem_we    = 1'b1;
				mem_wdata = IdW'(cmd.buffer_id);
			end
			if (cmd.op == bpa_pkg::OP_ACQ_ANY && open_q && !q_empty) begin
				mem_re = 1'b1;
			end
		end else if (state_q == ST_FILL && !fill_done) begin
			mem_we = 1'b1;
		end
	end

	// Free-id queue storage with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Sequencer: state, queue pointers and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			open_q   <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							bpa_pkg::OP_INIT: begin
								if (open_q) begin
									res_q   <= make_result(bpa_pkg::STATUS_OPEN,
										'0, '0, '0, '0);
									state_q <= ST_OUT;
								end else begin
									open_q   <= 1'b1;
									fill_q   <= '0;
									fill_n_q <= fill_limit;
									state_q  <= ST_FILL;
								end
							end
							bpa_pkg::OP_ACQ_ANY: begin
								if (!open_q || q_empty) begin
									res_q   <= make_result(bpa_pkg::STATUS_INVALID,
										'0, '0, '0, '0);
									state_q <= ST_OUT;
								end else begin
									rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
									count_q  <= count_q - 1'b1;
									state_q  <= ST_MUL;
								end
							end
							bpa_pkg::OP_ACQ_ID: begin
								if (!open_q) begin
									res_q   <= make_result(bpa_pkg::STATUS_INVALID,
										'0, '0, '0, '0);
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_MUL;
								end
							end
							bpa_pkg::OP_RELEASE: begin
								if (q_full) begin
									res_q <= make_result(bpa_pkg::STATUS_FULL,
										'0, '0, '0, '0);
								end else begin
									wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
									count_q  <= count_q + 1'b1;
									res_q    <= make_result(bpa_pkg::STATUS_OK,
										'0, '0, '0, '0);
								end
								state_q <= ST_OUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FILL: begin
					// Queue one fresh id per cycle until the count is reached or the queue fills.
					if (fill_done) begin
						res_q   <= make_result(bpa_pkg::STATUS_OK, '0, '0, '0, '0);
						state_q <= ST_OUT;
					end else begin
						wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
						count_q  <= count_q + 1'b1;
						fill_q   <= fill_q + 1'b1;
					end
				end
				ST_MUL: begin
					ok_q    <= (id_sel < cfg.buffer_count) && cmd_q.len_ok;
					id_q    <= id_sel;
					prod_q  <= ProdW'(id_sel) * ProdW'(cfg.buffer_length);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (ok_q) begin
						res_q <= make_result(bpa_pkg::STATUS_OK, id_q[9:0],
							cfg.base_address + 64'(prod_q), cmd_q.request_length,
							cfg.local_key);
					end else begin
						res_q <= make_result(bpa_pkg::STATUS_INVALID, '0, '0, '0, '0);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/buffer_pool_allocator_core.sv
// Top level of the buffer pool allocator: configuration registers, front, back and result queue.
// Depends on bpa_pkg, bpa_fifo, bpa_front and bpa_back.
//
//   Channel   Handshake             Payload
//   request   push / full           request  (op, buffer_id, request_length)
//   result    empty / pop           result   (status, granted_id, address, granted_length, key)
//   config    cfg_write             cfg_index, cfg_data
//
// Release, init while open and acquires that fail before the multiply go from idle straight
// to the output state in the back part; acquires that reach the grant arithmetic pass through
// queue read, multiply, add and output. Init queues min(buffer_count, MAX_BUFFERS) fresh ids,
// fewer when the queue fills first: the free-id memory has one write port, so fresh ids are
// queued one per cycle. The back part handles one command at a time.
// The two-entry command queue and result queue keep input and output stalls apart.
// Reset clears the pointers, counts and open flag at once; the id memory needs no clearing.
module buffer_pool_allocator_core #(
	parameter int MAX_BUFFERS = bpa_pkg::MaxBuffersDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bpa_pkg::request_t request,
	output logic              empty,
	input  logic              pop,
	output bpa_pkg::result_t  result,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	bpa_pkg::cfg_t    cfg_q;
	bpa_pkg::cmd_t    cmd;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_valid;
	bpa_pkg::result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpa_pkg::CfgBaseAddress:  cfg_q.base_address  <= cfg_data;
				bpa_pkg::CfgBufferLength: cfg_q.buffer_length <= cfg_data[31:0];
				bpa_pkg::CfgBufferCount:  cfg_q.buffer_count  <= cfg_data[10:0];
				bpa_pkg::CfgLocalKey:     cfg_q.local_key     <= cfg_data[31:0];
				default:                  cfg_q               <= cfg_q;
			endcase
		end
	end

	bpa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request       (request),
		.buffer_length (cfg_q.buffer_length),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty)
	);

	bpa_back #(
		.MAX_BUFFERS (MAX_BUFFERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result queue: a finished result waits here while the back part moves on.
	bpa_fifo #(
		.T     (bpa_pkg::result_t),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	// A waiting result never reports a length above the buffer length.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.granted_length <= cfg_q.buffer_length))
		else $error("result length exceeds buffer length");

	// A result that is not a grant carries only its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != bpa_pkg::STATUS_OK) |->
		(result.granted_id == '0 && result.address == '0 &&
		 result.granted_length == '0 && result.key == '0))
		else $error("failed result carries nonzero fields");

	// A grant with a nonzero length carries the configured key.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == bpa_pkg::STATUS_OK && result.granted_length != '0) |->
		(result.key == cfg_q.local_key))
		else $error("grant key differs from local key");

endmodule

FILE: test/tb.sv
// Testbench for buffer_pool_allocator_core: a directed table of requests, then random phases.
// Each result is checked against a pinned status or a predictor of the queue and grant arithmetic.
// Depends on bpa_pkg and the buffer_pool_allocator_core RTL.
module tb;

	localparam int PoolDepth = bpa_pkg::MaxBuffersDefault;
	localparam int TotalRequests = 1850;
	localparam int PhaseLength = 150;
	localparam int HoldOffCycles = 600;
	localparam int SettleCycles = 20;

	typedef enum int {
		MODE_DRAIN,
		MODE_FILL,
		MODE_MIXED
	} traffic_mode_t;

	typedef struct {
		bpa_pkg::op_t     op;
		logic [9:0]       id;
		logic [31:0]      length;
		bit               pinned;
		bpa_pkg::status_t status;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	bpa_pkg::request_t request = '0;
	logic              empty;
	logic              pop = 1'b0;
	bpa_pkg::result_t  result;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = bpa_pkg::CfgBaseAddress;
	logic [63:0]       cfg_data = '0;

	// Fixed expectation that travels with the request on the port, when the table gives one.
	logic             pinned_valid = 1'b0;
	bpa_pkg::result_t pinned_result = '0;

	// Predictor state: configuration shadow and the free-id queue.
	bpa_pkg::cfg_t pool_cfg = '0;
	logic [9:0]    free_id_store [PoolDepth];
	// Ten-bit pointers wrap at exactly the queue depth.
	logic [9:0]    free_head = '0;
	logic [9:0]    free_tail = '0;
	int unsigned   free_count = 0;
	logic          pool_is_open = 1'b0;
	bit            queue_ran_dry = 1'b0;

	bpa_pkg::result_t pending_results [$];
	int unsigned      mismatch_count = 0;
	int unsigned      sent_count = 0;
	bit               quiet_phase = 1'b0;
	bit               hold_off_request = 1'b0;

	// Directed requests. Only obvious outcomes are typed in; the rest go to the predictor.
	directed_row_t directed_rows [18] = '{
		'{bpa_pkg::OP_ACQ_ANY, 10'd0,    32'd0,         1'b1, bpa_pkg::STATUS_INVALID},
		'{bpa_pkg::OP_ACQ_ID,  10'd0,    32'd0,         1'b1, bpa_pkg::STATUS_INVALID},
		'{bpa_pkg::OP_RELEASE, 10'd1023, 32'hFFFF_FFFF, 1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_RELEASE, 10'd0,    32'd0,         1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_RELEASE, 10'd341,  32'd7,         1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_INIT,    10'd0,    32'd0,         1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_INIT,    10'd1023, 32'hFFFF_FFFF, 1'b1, bpa_pkg::STATUS_OPEN},
		'{bpa_pkg::OP_RELEASE, 10'd5,    32'd0,         1'b1, bpa_pkg::STATUS_FULL},
		'{bpa_pkg::OP_ACQ_ANY, 10'd0,    32'h0000_0100, 1'b0, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_ACQ_ANY, 10'd0,    32'h0000_0101, 1'b1, bpa_pkg::STATUS_INVALID},
		'{bpa_pkg::OP_ACQ_ANY, 10'd682,  32'd0,         1'b0, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_ACQ_ID,  10'd1023, 32'hFFFF_FFFF, 1'b1, bpa_pkg::STATUS_INVALID},
		'{bpa_pkg::OP_ACQ_ID,  10'd1023, 32'd0,         1'b0, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_ACQ_ID,  10'd0,    32'h0000_0080, 1'b0, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_RELEASE, 10'd1023, 32'd0,         1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_RELEASE, 10'd0,    32'd0,         1'b1, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_ACQ_ANY, 10'd0,    32'h0000_00FF, 1'b0, bpa_pkg::STATUS_OK},
		'{bpa_pkg::OP_ACQ_ID,  10'd512,  32'h0000_0100, 1'b0, bpa_pkg::STATUS_OK}
	};

	buffer_pool_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Append an id to the free queue; a full queue drops it.
	function automatic bit queue_free_id(logic [9:0] id);
		if (free_count >= PoolDepth) begin
			return 1'b0;
		end
		free_id_store[free_tail] = id;
		free_tail = free_tail + 10'd1;
		free_count++;
		return 1'b1;
	endfunction

	// Range and length checks, then the address arithmetic of a grant.
	function automatic bpa_pkg::result_t grant_buffer(logic [9:0] id, logic [31:0] length);
		bpa_pkg::result_t r;
		r = '0;
		if ({1'b0, id} >= pool_cfg.buffer_count || length > pool_cfg.buffer_length) begin
			r.status = bpa_pkg::STATUS_INVALID;
		end else begin
			r.status = bpa_pkg::STATUS_OK;
			r.granted_id = id;
			r.address = pool_cfg.base_address + 64'(id) * 64'(pool_cfg.buffer_length);
			r.granted_length = length;
			r.key = pool_cfg.local_key;
		end
		return r;
	endfunction

	// Expected result of one request; updates the queue and the open flag.
	function automatic bpa_pkg::result_t predict_allocation(bpa_pkg::request_t req);
		bpa_pkg::result_t r;
		int unsigned      fresh;
		r = '0;
		case (req.op)
			bpa_pkg::OP_INIT: begin
				if (pool_is_open) begin
					r.status = bpa_pkg::STATUS_OPEN;
				end else begin
					pool_is_open = 1'b1;
					fresh = (pool_cfg.buffer_count > PoolDepth) ? PoolDepth
						: pool_cfg.buffer_count;
					for (int i = 0; i < fresh; i++) begin
						void'(queue_free_id(10'(i)));
					end
					r.status = bpa_pkg::STATUS_OK;
				end
			end
			bpa_pkg::OP_ACQ_ANY: begin
				if (!pool_is_open) begin
					r.status = bpa_pkg::STATUS_INVALID;
				end else if (free_count == 0) begin
					r.status = bpa_pkg::STATUS_INVALID;
					queue_ran_dry = 1'b1;
				end else begin
					// The popped id leaves the queue even when its checks fail.
					r = grant_buffer(free_id_store[free_head], req.request_length);
					free_head = free_head + 10'd1;
					free_count--;
				end
			end
			bpa_pkg::OP_ACQ_ID: begin
				if (!pool_is_open) begin
					r.status = bpa_pkg::STATUS_INVALID;
				end else begin
					r = grant_buffer(req.buffer_id, req.request_length);
				end
			end
			default: begin
				r.status = queue_free_id(req.buffer_id) ? bpa_pkg::STATUS_OK
					: bpa_pkg::STATUS_FULL;
			end
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string what, input bpa_pkg::result_t want);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("Mismatch at %0t: %s", $time, what);
			$display("  expected status %0d id %0d address %h length %h key %h",
				want.status, want.granted_id, want.address, want.granted_length, want.key);
			$display("  actual   status %0d id %0d address %h length %h key %h",
				result.status, result.granted_id, result.address, result.granted_length,
				result.key);
		end
	endtask

	// Predict on every request transfer and check every result transfer.
	always @(posedge clk) begin : check_results
		bpa_pkg::result_t want;
		string            wrong;
		if (arst_n) begin
			if (push && !full) begin
				want = predict_allocation(request);
				if (pinned_valid) begin
					want = pinned_result;
				end
				pending_results.push_back(want);
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					note_mismatch("result with no request waiting", '0);
				end else begin
					want = pending_results.pop_front();
					wrong = "";
					if (result.status !== want.status) begin
						wrong = {wrong, " status"};
					end
					if (result.granted_id !== want.granted_id) begin
						wrong = {wrong, " granted_id"};
					end
					if (result.address !== want.address) begin
						wrong = {wrong, " address"};
					end
					if (result.granted_length !== want.granted_length) begin
						wrong = {wrong, " granted_length"};
					end
					if (result.key !== want.key) begin
						wrong = {wrong, " key"};
					end
					if (wrong != "") begin
						note_mismatch({"wrong field(s):", wrong}, want);
					end
				end
			end
		end
	end

	// Idle length: mostly none or short, now and then long; none in a quiet phase.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (quiet_phase || roll < 55) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Offer one request and hold it until the transfer.
	task automatic send_request(input bpa_pkg::request_t req, input bit has_pin,
		input bpa_pkg::result_t pin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		request <= req;
		pinned_valid <= has_pin;
		pinned_result <= pin;
		do begin
			@(posedge clk);
		end while (full);
		sent_count++;
	endtask

	// Stop offering and wait until every expected result has arrived.
	task automatic wait_for_results();
		push <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_results.size() != 0);
	endtask

	// Write all four registers, one per cycle, and update the shadow copy.
	task automatic write_pool_config(input bpa_pkg::cfg_t next);
		cfg_write <= 1'b1;
		cfg_index <= bpa_pkg::CfgBaseAddress;
		cfg_data <= next.base_address;
		@(posedge clk);
		cfg_index <= bpa_pkg::CfgBufferLength;
		cfg_data <= 64'(next.buffer_length);
		@(posedge clk);
		cfg_index <= bpa_pkg::CfgBufferCount;
		cfg_data <= 64'(next.buffer_count);
		@(posedge clk);
		cfg_index <= bpa_pkg::CfgLocalKey;
		cfg_data <= 64'(next.local_key);
		@(posedge clk);
		cfg_write <= 1'b0;
		pool_cfg = next;
	endtask

	// Register settings per phase; the extremes come around in turn.
	function automatic bpa_pkg::cfg_t pick_phase_config(int phase);
		bpa_pkg::cfg_t c;
		case (phase % 4)
			0: c.base_address = '0;
			1: c.base_address = '1;
			default: c.base_address = {$urandom, $urandom};
		endcase
		case ((phase + 1) % 5)
			0: c.buffer_length = '0;
			1: c.buffer_length = '1;
			2: c.buffer_length = $urandom_range(4096, 1);
			default: c.buffer_length = $urandom;
		endcase
		case ((phase + 2) % 6)
			0: c.buffer_count = '0;
			1: c.buffer_count = 11'd1;
			2: c.buffer_count = 11'(PoolDepth);
			3: c.buffer_count = '1;
			default: c.buffer_count = 11'($urandom_range(PoolDepth, 2));
		endcase
		case ((phase + 3) % 3)
			0: c.local_key = '0;
			1: c.local_key = '1;
			default: c.local_key = $urandom;
		endcase
		return c;
	endfunction

	// Random request whose op mix follows the traffic mode.
	function automatic bpa_pkg::request_t random_request(traffic_mode_t mode);
		bpa_pkg::request_t req;
		int                roll;
		int                any_cut;
		int                id_cut;
		int                rel_cut;
		int unsigned       id_limit;
		id_limit = (pool_cfg.buffer_count == 0 || pool_cfg.buffer_count > PoolDepth)
			? PoolDepth : pool_cfg.buffer_count;
		req.buffer_id = ($urandom_range(3) == 0) ? 10'($urandom)
			: 10'($urandom_range(id_limit - 1, 0));
		case ($urandom_range(9))
			0: req.request_length = '0;
			1: req.request_length = '1;
			2: req.request_length = $urandom;
			3: req.request_length = pool_cfg.buffer_length + 32'd1;
			default: req.request_length = $urandom_range(pool_cfg.buffer_length, 0);
		endcase
		case (mode)
			MODE_DRAIN: begin
				any_cut = 90;
				id_cut = 95;
				rel_cut = 99;
			end
			MODE_FILL: begin
				any_cut = 15;
				id_cut = 27;
				rel_cut = 97;
			end
			default: begin
				any_cut = 40;
				id_cut = 65;
				rel_cut = 95;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < any_cut) begin
			req.op = bpa_pkg::OP_ACQ_ANY;
		end else if (roll < id_cut) begin
			req.op = bpa_pkg::OP_ACQ_ID;
		end else if (roll < rel_cut) begin
			req.op = bpa_pkg::OP_RELEASE;
		end else begin
			req.op = bpa_pkg::OP_INIT;
		end
		return req;
	endfunction

	// Result side: random pop gaps, plus one long hold-off on request.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				gap = HoldOffCycles;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(posedge clk);
			end while (empty);
		end
	end

	// Request side: reset, directed table, then random phases.
	initial begin : stimulus
		bpa_pkg::cfg_t     next_cfg;
		bpa_pkg::request_t req;
		bpa_pkg::result_t  pin;
		traffic_mode_t     mode;
		int                phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Count above the queue depth, so the first init fills the queue after releases.
		next_cfg.base_address = 64'h0000_0040_0000_0000;
		next_cfg.buffer_length = 32'h0000_0100;
		next_cfg.buffer_count = '1;
		next_cfg.local_key = 32'hA5A5_5A5A;
		write_pool_config(next_cfg);

		foreach (directed_rows[i]) begin
			req.op = directed_rows[i].op;
			req.buffer_id = directed_rows[i].id;
			req.request_length = directed_rows[i].length;
			pin = '0;
			pin.status = directed_rows[i].status;
			send_request(req, directed_rows[i].pinned, pin);
		end

		phase = 0;
		while (sent_count < TotalRequests) begin
			wait_for_results();
			write_pool_config(pick_phase_config(phase));
			quiet_phase = (phase % 5 == 3);
			if (phase == 2) begin
				hold_off_request = 1'b1;
			end
			// Drain until the queue has run dry once, then rotate the traffic mix.
			if (!queue_ran_dry) begin
				mode = MODE_DRAIN;
			end else begin
				case (phase % 3)
					0: mode = MODE_FILL;
					1: mode = MODE_MIXED;
					default: mode = MODE_DRAIN;
				endcase
			end
			for (int n = 0; n < PhaseLength && sent_count < TotalRequests; n++) begin
				send_request(random_request(mode), 1'b0, '0);
			end
			phase++;
		end

		wait_for_results();
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
